// ===== rtl/rau_pkg.sv =====
package rau_pkg;

    // Operand and result width; the model fixes it at 32.
    localparam int OPW = 32;
    localparam int MW  = 2 * OPW;   // magnitude width of products
    localparam int CW  = $clog2(MW + 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_less;
        logic               is_equal;
        logic               is_greater;
        logic [1:0]         status;
    } t_out;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Channel   | Ports                              | Direction
// command   | i_start, o_busy, i_cmd (t_in)      | in
// result    | o_valid, o_res (t_out)             | out
//
// An error or undefined opcode goes straight to the output state after acceptance;
// a compare runs two shift-add products. Arithmetic runs up to three products,
// a subtractive binary GCD over 64-bit magnitudes (one shift or subtract per
// cycle) and two restoring divisions.
// Reset is synchronous; it idles the sequencer. o_busy stays high from
// acceptance until the cycle o_valid pulses; results cannot be stalled.
module rational_arithmetic_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rau_pkg::t_in    i_cmd,
    output logic            o_busy,
    output logic            o_valid,
    output rau_pkg::t_out   o_res
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIVN = 4'd6;
    localparam logic [3:0] S_DIVD = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]     r_state;
    logic [2:0]     r_op;
    logic           r_an, r_bn;
    logic [OPW-1:0] r_anm, r_adm, r_bnm, r_bdm;
    logic [MW-1:0]  r_t1, r_t2, r_rd, r_rn;
    logic           r_neg;
    logic [MW-1:0]  r_gu, r_gv;
    logic [CW-1:0]  r_gk;
    logic [MW-1:0]  r_g;
    logic [MW-1:0]  r_q, r_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_mgo;
    logic [OPW-1:0] r_mx, r_my;
    t_out           r_res;
    logic           r_valid;

    logic           m_done;
    logic [MW-1:0]  m_p;

    rau_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_mgo),
        .i_x    (r_mx),
        .i_y    (r_my),
        .o_done (m_done),
        .o_p    (m_p)
    );

    // operand magnitudes and signs
    logic [OPW-1:0] a_nm, a_dm, b_nm, b_dm;
    logic           a_ng, b_ng;
    always_comb begin
        a_nm = i_cmd.a_num[OPW-1] ? -i_cmd.a_num : i_cmd.a_num;
        a_dm = i_cmd.a_den[OPW-1] ? -i_cmd.a_den : i_cmd.a_den;
        b_nm = i_cmd.b_num[OPW-1] ? -i_cmd.b_num : i_cmd.b_num;
        b_dm = i_cmd.b_den[OPW-1] ? -i_cmd.b_den : i_cmd.b_den;
        a_ng = (a_nm != '0) && (i_cmd.a_num[OPW-1] != i_cmd.a_den[OPW-1]);
        b_ng = (b_nm != '0) && (i_cmd.b_num[OPW-1] != i_cmd.b_den[OPW-1]);
    end

    logic sb;
    assign sb = (r_op == OP_SUB) ? !r_bn : r_bn;

    // restoring divide step
    logic [MW:0]   dv_try;
    logic [MW-1:0] dv_src;
    logic [$clog2(MW)-1:0] dv_idx;
    assign dv_idx = r_cnt[$clog2(MW)-1:0] - 1'b1;
    assign dv_src = (r_state == S_DIVN) ? r_rn : r_rd;
    assign dv_try = {r_rem, dv_src[dv_idx]} - {1'b0, r_g};

    // final range check
    logic [MW-1:0] lim;
    logic          ovf;
    assign lim = MW'(1) << (OPW - 1);
    assign ovf = (r_rd > lim - 1'b1) || (r_rn > (r_neg ? lim : lim - 1'b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_mgo   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_mgo   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op  <= i_cmd.opcode;
                        r_an  <= a_ng;  r_bn  <= b_ng;
                        r_anm <= a_nm;  r_adm <= a_dm;
                        r_bnm <= b_nm;  r_bdm <= b_dm;
                        r_res <= '0;
                        if (i_cmd.opcode > OP_CMP) begin
                            r_state <= S_OUT;
                        end else if (a_dm == '0 ||
                                     (i_cmd.opcode != OP_NEG && b_dm == '0) ||
                                     (i_cmd.opcode == OP_DIV && b_nm == '0)) begin
                            r_res.status <= ST_ZDEN;
                            r_state      <= S_OUT;
                        end else if (i_cmd.opcode == OP_NEG) begin
                            r_rn    <= MW'(a_nm);
                            r_rd    <= MW'(a_dm);
                            r_neg   <= !a_ng;
                            r_state <= S_SUM;
                        end else begin
                            // first product: a_num*b_den, or a_num*b_num for mul
                            r_mx    <= a_nm;
                            r_my    <= (i_cmd.opcode == OP_MUL) ? b_nm : b_dm;
                            r_mgo   <= 1'b1;
                            r_state <= S_M1;
                        end
                    end
                end
                S_M1: if (m_done) begin
                    r_t1  <= m_p;
                    r_mgo <= 1'b1;
                    if (r_op == OP_MUL) begin
                        r_mx <= r_adm; r_my <= r_bdm; r_state <= S_M3;
                    end else if (r_op == OP_DIV) begin
                        r_mx <= r_adm; r_my <= r_bnm; r_state <= S_M3;
                    end else begin
                        r_mx <= r_bnm; r_my <= r_adm; r_state <= S_M2;
                    end
                end
                S_M2: if (m_done) begin
                    r_t2 <= m_p;
                    if (r_op == OP_CMP) begin
                        if (r_an != r_bn) begin
                            r_res.is_less    <= r_an;
                            r_res.is_greater <= !r_an;
                        end else if (r_t1 == m_p) begin
                            r_res.is_equal   <= 1'b1;
                        end else begin
                            r_res.is_less    <= (r_t1 < m_p) ^ r_an;
                            r_res.is_greater <= (r_t1 > m_p) ^ r_an;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_mx <= r_adm; r_my <= r_bdm; r_mgo <= 1'b1;
                        r_state <= S_M3;
                    end
                end
                S_M3: if (m_done) begin
                    r_rd <= m_p;
                    if (r_op == OP_MUL || r_op == OP_DIV) begin
                        r_rn  <= r_t1;
                        r_neg <= r_an != r_bn;
                    end else if (r_an == sb) begin
                        r_rn <= r_t1 + r_t2;  r_neg <= r_an;
                    end else if (r_t1 >= r_t2) begin
                        r_rn <= r_t1 - r_t2;  r_neg <= r_an;
                    end else begin
                        r_rn <= r_t2 - r_t1;  r_neg <= sb;
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // set up binary GCD; rn==0 gives gcd = rd
                    if (r_rn == '0) r_neg <= 1'b0;
                    r_gu    <= r_rn;
                    r_gv    <= r_rd;
                    r_gk    <= '0;
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    if (r_gu == '0 || r_gv == '0 || r_gu == r_gv) begin
                        r_g     <= (r_gu == '0 ? r_gv : r_gu) << r_gk;
                        r_cnt   <= CW'(MW);
                        r_rem   <= '0;
                        r_state <= S_DIVN;
                    end else if (!r_gu[0] && !r_gv[0]) begin
                        r_gu <= r_gu >> 1; r_gv <= r_gv >> 1; r_gk <= r_gk + 1'b1;
                    end else if (!r_gu[0]) begin
                        r_gu <= r_gu >> 1;
                    end else if (!r_gv[0]) begin
                        r_gv <= r_gv >> 1;
                    end else if (r_gu > r_gv) begin
                        r_gu <= r_gu - r_gv;
                    end else begin
                        r_gv <= r_gv - r_gu;
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (!dv_try[MW]) begin
                        r_rem <= dv_try[MW-1:0];
                        r_q   <= {r_q[MW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[MW-2:0], dv_src[dv_idx]};
                        r_q   <= {r_q[MW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_cnt <= CW'(MW);
                        r_rem <= '0;
                        if (r_state == S_DIVN) begin
                            r_rn    <= dv_try[MW] ? {r_q[MW-2:0], 1'b0}
                                                  : {r_q[MW-2:0], 1'b1};
                            r_state <= S_DIVD;
                        end else begin
                            r_rd    <= dv_try[MW] ? {r_q[MW-2:0], 1'b0}
                                                  : {r_q[MW-2:0], 1'b1};
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (ovf) begin
                        r_res.status <= ST_OVF;
                    end else begin
                        r_res.res_num <= r_neg ? -r_rn[OPW-1:0] : r_rn[OPW-1:0];
                        r_res.res_den <= r_rd[OPW-2:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    // a result pulse lasts one cycle
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result strobe");
    // accepted command leaves idle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
    // at most one compare flag is set on any result with OK status
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == ST_OK) |->
        $onehot0({o_res.is_less, o_res.is_equal, o_res.is_greater}))
        else $error("compare flags collide");
`endif

endmodule

// ===== rtl/rau_mul.sv =====
// Shift-add multiplier: one bit of the multiplier per cycle.
module rau_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [rau_pkg::OPW-1:0] i_x,
    input  logic [rau_pkg::OPW-1:0] i_y,
    output logic                  o_done,
    output logic [rau_pkg::MW-1:0]  o_p
);
    import rau_pkg::*;

    logic [MW-1:0]  r_acc, r_x;
    logic [OPW-1:0] r_y;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(OPW);
            r_acc  <= '0;
            r_x    <= MW'(i_x);
            r_y    <= i_y;
        end else if (r_busy) begin
            if (r_y[0]) r_acc <= r_acc + r_x;
            r_x   <= r_x << 1;
            r_y   <= r_y >> 1;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(1)) && !i_go;
    assign o_p    = r_y[0] ? r_acc + r_x : r_acc;

endmodule
